### hw/rtl/dd_pkg.sv
// shared types and constants of the deadlock detector
`default_nettype none

package dd_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int MAX_RES     = 8;
  localparam int VALUE_WIDTH = 16;

  localparam int PIDX_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RIDX_W    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int ADDR_W    = PIDX_W + RIDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int PCNT_W    = $clog2(MAX_PROCS + 1);
  localparam int RCNT_W    = $clog2(MAX_RES + 1);

  localparam int NUM_PROCS_W = 5;
  localparam int NUM_RES_W   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_PROCS = 2'd0,
    CFG_NUM_RES   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REQ_LOAD_AVAIL = 2'd0,
    REQ_LOAD_ALLOC = 2'd1,
    REQ_LOAD_REQ   = 2'd2,
    REQ_RUN        = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_ZSCAN,
    ST_PSCAN,
    ST_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_DEAD
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  proc_index;
    logic [2:0]  res_index;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] proc_id;
    logic       deadlocked;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/deadlock_detector_unit.sv
// deadlock detector: resource tables in memories, sequential detection run
//
// Input channel (in_valid / in_stall / in_item) takes load requests and run
// requests. A load writes one element of the available vector, the
// allocation matrix or the request matrix. A run walks the matrices one
// element per cycle through the single read port of each memory: a
// zero-allocation sweep of num_procs rows, then passes over the unfinished
// rows (a finished row is skipped). The run ends with one result per
// process in finish order (last marks the final one), or one deadlock
// result. New requests are stalled while a run is in progress.
// Output channel (out_valid / out_stall / out_item) is a single output
// register; while the receiver stalls it holds the result and the run
// waits for it to drain.
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready:
// index 0 is num_procs, index 1 is num_res.
// After reset both memories are swept to zero, one entry per cycle over all
// 128 entries; input stays stalled until it is done.
`default_nettype none

module deadlock_detector_unit
  import dd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [NUM_PROCS_W-1:0] np_raw;
  logic [NUM_RES_W-1:0]   nr_raw;
  logic [PCNT_W-1:0]      np;
  logic [RCNT_W-1:0]      nr;

  logic [VALUE_WIDTH-1:0] avail   [MAX_RES];
  logic [VALUE_WIDTH-1:0] work    [MAX_RES];
  logic [VALUE_WIDTH-1:0] row_buf [MAX_RES];
  logic [MAX_PROCS-1:0]   fin;

  logic [VALUE_WIDTH-1:0] alloc_mem [MEM_DEPTH];
  logic [VALUE_WIDTH-1:0] req_mem   [MEM_DEPTH];
  logic [VALUE_WIDTH-1:0] alloc_q, req_q;
  logic [PIDX_W-1:0]      ord_mem [MAX_PROCS];
  logic [PIDX_W-1:0]      ord_q;

  logic [ADDR_W-1:0]      clr_addr;
  logic [PIDX_W-1:0]      p;
  logic [RCNT_W-1:0]      r_rd;
  logic                   rd_valid, rd_last;
  logic [RIDX_W-1:0]      rd_r;
  logic                   fits, azero, in_pass;
  logic [PCNT_W-1:0]      count, count_next, prev;
  logic [PIDX_W-1:0]      e;

  logic                   in_acc, res_ok, proc_ok;
  logic [RIDX_W-1:0]      in_r;
  logic [PIDX_W-1:0]      in_p;
  logic                   wr_alloc, wr_req;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic                   skip, issue, finish, row_end, out_free, emit_last;
  logic                   out_load;
  out_item_t              out_load_item;

  // clamp config to the usable ranges
  always_comb begin
    if (np_raw == '0) np = PCNT_W'(1);
    else if (int'(np_raw) > MAX_PROCS) np = PCNT_W'(MAX_PROCS);
    else np = PCNT_W'(np_raw);
    if (nr_raw == '0) nr = RCNT_W'(1);
    else if (int'(nr_raw) > MAX_RES) nr = RCNT_W'(MAX_RES);
    else nr = RCNT_W'(nr_raw);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      np_raw <= NUM_PROCS_W'(1);
      nr_raw <= NUM_RES_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_NUM_PROCS) np_raw <= NUM_PROCS_W'(cfg_data);
      if (cfg_index == CFG_NUM_RES) nr_raw <= NUM_RES_W'(cfg_data);
    end
  end

  // input decode
  assign in_acc  = in_valid && !in_stall;
  assign res_ok  = int'(in_item.res_index) < MAX_RES;
  assign proc_ok = int'(in_item.proc_index) < MAX_PROCS;
  assign in_r    = RIDX_W'(in_item.res_index);
  assign in_p    = PIDX_W'(in_item.proc_index);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    skip          = 1'b0;
    issue         = 1'b0;
    finish        = 1'b0;
    out_load      = 1'b0;
    out_load_item = '0;
    out_free      = !out_valid || !out_stall;
    row_end       = (PCNT_W'(p) + PCNT_W'(1)) == np;
    emit_last     = (PCNT_W'(e) + PCNT_W'(1)) == np;
    count_next    = count;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == {ADDR_W{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_item.req_type == REQ_RUN) state_next = ST_INIT;
      end
      ST_INIT: begin
        state_next = ST_ZSCAN;
      end
      ST_ZSCAN, ST_PSCAN: begin
        skip  = (state == ST_PSCAN) && fin[p] && (r_rd == '0) && !rd_valid;
        issue = !skip && (r_rd < nr);
        if (skip || (rd_valid && rd_last)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        finish     = in_pass ? fits : azero;
        count_next = count + PCNT_W'(finish);
        if (!row_end) state_next = in_pass ? ST_PSCAN : ST_ZSCAN;
        else if (count_next == np) state_next = ST_EMIT_RD;
        else if (in_pass && count_next == prev) state_next = ST_DEAD;
        else state_next = ST_PSCAN;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_load_item.proc_id = 4'(ord_q);
          out_load_item.last    = emit_last;
          state_next            = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_DEAD: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_load_item.deadlocked = 1'b1;
          out_load_item.last       = 1'b1;
          state_next               = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory write port: clearing sweep or load request
  always_comb begin
    wr_alloc = 1'b0;
    wr_req   = 1'b0;
    wr_addr  = {in_p, in_r};
    wr_data  = VALUE_WIDTH'(in_item.value);
    if (state == ST_CLEAR) begin
      wr_alloc = 1'b1;
      wr_req   = 1'b1;
      wr_addr  = clr_addr;
      wr_data  = '0;
    end else if (in_acc && res_ok && proc_ok) begin
      wr_alloc = in_item.req_type == REQ_LOAD_ALLOC;
      wr_req   = in_item.req_type == REQ_LOAD_REQ;
    end
  end

  assign rd_addr = {p, r_rd[RIDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_alloc) alloc_mem[wr_addr] <= wr_data;
    if (wr_req) req_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    alloc_q <= alloc_mem[rd_addr];
    req_q   <= req_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && finish) ord_mem[count[PIDX_W-1:0]] <= p;
  end

  always_ff @(posedge clk) begin
    ord_q <= ord_mem[e];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_RES; r++) avail[r] <= '0;
    end else if (in_acc && res_ok && in_item.req_type == REQ_LOAD_AVAIL) begin
      avail[in_r] <= VALUE_WIDTH'(in_item.value);
    end
  end

  // row scan and decision
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      fin      <= '0;
      count    <= '0;
      prev     <= '0;
      in_pass  <= 1'b0;
      p        <= '0;
      r_rd     <= '0;
      fits     <= 1'b1;
      azero    <= 1'b1;
      e        <= '0;
    end else begin
      rd_valid <= issue;
      rd_r     <= r_rd[RIDX_W-1:0];
      rd_last  <= (r_rd + RCNT_W'(1)) == nr;
      if (issue) r_rd <= r_rd + RCNT_W'(1);
      if (skip) fits <= 1'b0;
      if (rd_valid) begin
        if (req_q > work[rd_r]) fits <= 1'b0;
        if (alloc_q != '0) azero <= 1'b0;
        row_buf[rd_r] <= alloc_q;
      end
      case (state)
        ST_INIT: begin
          for (int r = 0; r < MAX_RES; r++) work[r] <= avail[r];
          fin     <= '0;
          count   <= '0;
          prev    <= '0;
          in_pass <= 1'b0;
          p       <= '0;
          r_rd    <= '0;
          fits    <= 1'b1;
          azero   <= 1'b1;
          e       <= '0;
        end
        ST_DECIDE: begin
          count <= count_next;
          r_rd  <= '0;
          fits  <= 1'b1;
          azero <= 1'b1;
          if (finish) fin[p] <= 1'b1;
          // allocation of a process that fits returns to work, saturating
          if (in_pass && finish) begin
            for (int r = 0; r < MAX_RES; r++) begin
              if (r < int'(nr)) begin
                if ({1'b0, work[r]} + {1'b0, row_buf[r]} > {1'b0, {VALUE_WIDTH{1'b1}}})
                  work[r] <= {VALUE_WIDTH{1'b1}};
                else
                  work[r] <= work[r] + row_buf[r];
              end
            end
          end
          if (!row_end) begin
            p <= p + PIDX_W'(1);
          end else begin
            p       <= '0;
            in_pass <= 1'b1;
            prev    <= count_next;
          end
        end
        ST_EMIT_LD: begin
          if (out_free) e <= e + PIDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_item <= out_load_item;
  end

endmodule

`default_nettype wire

### hw/rtl/dd_checker.sv
// port-level checks of the deadlock detector, bound to the top level
`default_nettype none

module dd_checker
  import dd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire in_item_t              in_item,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire out_item_t             out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // deadlock result is a single final result with process zero
  a_dead_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.deadlocked |-> out_item.last && out_item.proc_id == '0)
    else $error("malformed deadlock result");

  // a run request makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.req_type == REQ_RUN |=> in_stall)
    else $error("request accepted during a run");

  // memory clearing follows reset
  a_rst_busy: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("not clearing after reset");

endmodule

bind deadlock_detector_unit dd_checker u_dd_checker (.*);

`default_nettype wire

### test/deadlock_detector_unit_test.sv
// self-checking bench for the deadlock detector: directed request table, then random phases
module deadlock_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dd_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 60;
  localparam int NUM_PHASES    = 8;
  localparam int SCRIPT_LEN    = 27;

  typedef out_item_t result_q_t[$];

  typedef enum logic [1:0] {QUIET, SEND_GAPS, RECV_STALLS, BOTH_SLOW} idle_mode_e;

  typedef struct packed {
    logic       is_cfg;
    logic [4:0] procs;
    logic [4:0] res;
    in_item_t   item;
    logic       typed;
    out_item_t  want;
  } script_row_t;

  typedef struct packed {
    logic [4:0] procs;
    logic [4:0] res;
    idle_mode_e mode;
    logic       long_hold;
    logic       mid_drain;
  } phase_t;

  localparam out_item_t NO_RESULT = '0;
  localparam out_item_t ONLY_P0   = '{4'd0, 1'b0, 1'b1};
  localparam out_item_t DEADLOCK  = '{4'd0, 1'b1, 1'b1};

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // reset state: one process, nothing allocated
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b1, ONLY_P0},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_ALLOC, 4'd0, 3'd0, 16'h0005}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b1, ONLY_P0},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_REQ, 4'd0, 3'd0, 16'h0001}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b1, DEADLOCK},
    // zero counts act as one
    '{1'b1, 5'd0, 5'd0, '0, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd15, 3'd7, 16'hFFFF}, 1'b1, DEADLOCK},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_AVAIL, 4'd15, 3'd0, 16'hFFFF}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b1, ONLY_P0},
    '{1'b1, 5'd16, 5'd8, '0, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_ALLOC, 4'd15, 3'd7, 16'hFFFF}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_REQ, 4'd15, 3'd7, 16'hFFFF}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_AVAIL, 4'd0, 3'd7, 16'h8000}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b0, NO_RESULT},
    // work saturates at the top value
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_ALLOC, 4'd14, 3'd7, 16'h8000}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b0, NO_RESULT},
    // request equal to work exactly
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_REQ, 4'd14, 3'd3, 16'hAAAA}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_ALLOC, 4'd3, 3'd3, 16'h5555}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_AVAIL, 4'd0, 3'd3, 16'h5555}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b0, NO_RESULT},
    // counts above the maximum clamp
    '{1'b1, 5'd31, 5'd15, '0, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b0, NO_RESULT},
    // only process 0 finished up front, process 1 still has to get through a pass
    '{1'b1, 5'd2, 5'd1, '0, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_ALLOC, 4'd0, 3'd0, 16'h0000}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_ALLOC, 4'd1, 3'd0, 16'h0003}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_LOAD_REQ, 4'd1, 3'd0, 16'h0002}, 1'b0, NO_RESULT},
    '{1'b0, 5'd0, 5'd0, '{REQ_RUN, 4'd0, 3'd0, 16'h0000}, 1'b0, NO_RESULT}
  };

  localparam phase_t PHASES [NUM_PHASES] = '{
    '{5'd4,  5'd2,  QUIET,       1'b1, 1'b0},
    '{5'd16, 5'd8,  SEND_GAPS,   1'b0, 1'b0},
    '{5'd1,  5'd1,  RECV_STALLS, 1'b0, 1'b0},
    '{5'd8,  5'd3,  BOTH_SLOW,   1'b0, 1'b1},
    '{5'd31, 5'd24, QUIET,       1'b0, 1'b0},
    '{5'd6,  5'd8,  RECV_STALLS, 1'b1, 1'b0},
    '{5'd3,  5'd1,  SEND_GAPS,   1'b0, 1'b1},
    '{5'd16, 5'd2,  BOTH_SLOW,   1'b0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [VALUE_WIDTH-1:0] avail_tbl [MAX_RES];
  logic [VALUE_WIDTH-1:0] alloc_tbl [MAX_PROCS][MAX_RES];
  logic [VALUE_WIDTH-1:0] need_tbl  [MAX_PROCS][MAX_RES];
  logic [NUM_PROCS_W-1:0] num_procs_reg;
  logic [NUM_RES_W-1:0]   num_res_reg;

  out_item_t finish_queue[$];
  out_item_t oldest;

  int  mismatches;
  int  loads_sent;
  int  runs_sent;
  int  orders_seen;
  int  deadlocks_seen;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_left;
  bit  hold_pending;

  deadlock_detector_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("deadlock_detector_unit_test NOT OK");
    $finish;
  end

  function automatic int active_procs();
    if (num_procs_reg == 0) return 1;
    if (num_procs_reg > MAX_PROCS) return MAX_PROCS;
    return int'(num_procs_reg);
  endfunction

  function automatic int active_res();
    if (num_res_reg == 0) return 1;
    if (num_res_reg > MAX_RES) return MAX_RES;
    return int'(num_res_reg);
  endfunction

  function automatic result_q_t detect_deadlock();
    int                     np;
    int                     nr;
    int                     done_cnt;
    int                     prev_cnt;
    bit                     fits;
    bit                     zero_row;
    bit                     finished [MAX_PROCS];
    logic [3:0]             order [MAX_PROCS];
    logic [VALUE_WIDTH-1:0] work [MAX_RES];
    logic [VALUE_WIDTH:0]   sum;
    out_item_t              r;
    result_q_t              res;
    np = active_procs();
    nr = active_res();
    done_cnt = 0;
    for (int i = 0; i < MAX_RES; i++) work[i] = (i < nr) ? avail_tbl[i] : '0;
    for (int p = 0; p < MAX_PROCS; p++) finished[p] = 1'b0;
    for (int p = 0; p < np; p++) begin
      zero_row = 1'b1;
      for (int i = 0; i < nr; i++) if (alloc_tbl[p][i] != 0) zero_row = 1'b0;
      if (zero_row) begin
        finished[p] = 1'b1;
        order[done_cnt] = 4'(p);
        done_cnt++;
      end
    end
    while (done_cnt < np) begin
      prev_cnt = done_cnt;
      for (int p = 0; p < np; p++) begin
        if (!finished[p]) begin
          fits = 1'b1;
          for (int i = 0; i < nr; i++) if (need_tbl[p][i] > work[i]) fits = 1'b0;
          if (fits) begin
            finished[p] = 1'b1;
            order[done_cnt] = 4'(p);
            done_cnt++;
            // allocation goes back to work right away, saturating
            for (int i = 0; i < nr; i++) begin
              sum = {1'b0, work[i]} + {1'b0, alloc_tbl[p][i]};
              work[i] = sum[VALUE_WIDTH] ? '1 : sum[VALUE_WIDTH-1:0];
            end
          end
        end
      end
      if (done_cnt == prev_cnt) begin
        res.push_back(DEADLOCK);
        return res;
      end
    end
    for (int p = 0; p < np; p++) begin
      r.proc_id    = order[p];
      r.deadlocked = 1'b0;
      r.last       = (p == np - 1);
      res.push_back(r);
    end
    return res;
  endfunction

  function automatic result_q_t model_request(in_item_t it);
    result_q_t none;
    case (it.req_type)
      REQ_LOAD_AVAIL: avail_tbl[it.res_index] = it.value;
      REQ_LOAD_ALLOC: alloc_tbl[it.proc_index][it.res_index] = it.value;
      REQ_LOAD_REQ:   need_tbl[it.proc_index][it.res_index] = it.value;
      default:        return detect_deadlock();
    endcase
    return none;
  endfunction

  function automatic in_item_t random_load();
    in_item_t it;
    it.req_type   = 2'($urandom_range(0, 2));
    // mostly inside the active rows and columns, sometimes anywhere
    it.proc_index = ($urandom_range(7) == 0) ? 4'($urandom)
                                             : 4'($urandom_range(active_procs() - 1));
    it.res_index  = ($urandom_range(7) == 0) ? 3'($urandom)
                                             : 3'($urandom_range(active_res() - 1));
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: it.value = 16'($urandom_range(3));
      6, 7:             it.value = 16'($urandom_range(12));
      8:                it.value = 16'hFFFF - 16'($urandom_range(3));
      default:          it.value = 16'($urandom);
    endcase
    if (it.req_type == REQ_LOAD_AVAIL && it.value < 16'd2) it.value = 16'($urandom_range(2, 10));
    return it;
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic send_request(in_item_t it, logic typed, out_item_t want);
    result_q_t fresh;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fresh = model_request(it);
    if (typed) begin
      finish_queue.push_back(want);
    end else begin
      foreach (fresh[i]) finish_queue.push_back(fresh[i]);
    end
    if (it.req_type == REQ_RUN) runs_sent++;
    else loads_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (finish_queue.size() != 0) @(posedge clk);
  endtask

  // loads are written into registered memories, so give the block a moment before a config write
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [4:0] procs, logic [4:0] res);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NUM_PROCS;
    cfg_data  <= procs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    num_procs_reg = procs;
    cfg_index <= CFG_NUM_RES;
    cfg_data  <= res;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    num_res_reg = res[NUM_RES_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (out_item.deadlocked) deadlocks_seen++;
      else orders_seen++;
      if (finish_queue.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: %p", out_item));
      end else begin
        oldest = finish_queue.pop_front();
        if (out_item.proc_id !== oldest.proc_id)
          flag_mismatch($sformatf("proc_id %0d, expected %0d", out_item.proc_id,
                                  oldest.proc_id));
        if (out_item.deadlocked !== oldest.deadlocked)
          flag_mismatch($sformatf("deadlocked %b, expected %b", out_item.deadlocked,
                                  oldest.deadlocked));
        if (out_item.last !== oldest.last)
          flag_mismatch($sformatf("last %b, expected %b", out_item.last, oldest.last));
      end
    end
  end

  initial begin
    phase_t   ph;
    in_item_t it;
    int       sent;
    int       n_loads;
    bit       paused;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NUM_PROCS;
    cfg_data  = '0;
    rst       = 1'b1;
    num_procs_reg = 1;
    num_res_reg   = 1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    hold_pending   = 1'b0;
    for (int i = 0; i < MAX_RES; i++) avail_tbl[i] = '0;
    for (int p = 0; p < MAX_PROCS; p++) begin
      for (int i = 0; i < MAX_RES; i++) begin
        alloc_tbl[p][i] = '0;
        need_tbl[p][i]  = '0;
      end
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].is_cfg) begin
        settle();
        set_config(SCRIPT[i].procs, SCRIPT[i].res);
      end else begin
        send_request(SCRIPT[i].item, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    for (int k = 0; k < NUM_PHASES; k++) begin
      ph = PHASES[k];
      settle();
      set_config(ph.procs, ph.res);
      send_idle_pct  = (ph.mode == SEND_GAPS) ? 87 : (ph.mode == BOTH_SLOW) ? 12 : 0;
      recv_stall_pct = (ph.mode == RECV_STALLS) ? 87 : (ph.mode == BOTH_SLOW) ? 12 : 0;
      if (ph.long_hold) hold_pending = 1'b1;
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        // a burst of table loads, usually followed by a detection run
        n_loads = $urandom_range(0, 10);
        repeat (n_loads) begin
          send_request(random_load(), 1'b0, NO_RESULT);
          sent++;
        end
        if ($urandom_range(7) != 0) begin
          it = '{REQ_RUN, 4'($urandom), 3'($urandom), 16'($urandom)};
          send_request(it, 1'b0, NO_RESULT);
          sent++;
        end
        if (ph.mid_drain && !paused && sent >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d table loads and %0d detection runs across %0d traffic phases",
             loads_sent, runs_sent, NUM_PHASES);
    $display("checked %0d finish-order results and %0d deadlock reports",
             orders_seen, deadlocks_seen);
    if (mismatches == 0 && finish_queue.size() == 0) begin
      $display("deadlock_detector_unit_test OK");
    end else begin
      $display("deadlock_detector_unit_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dd_pkg.sv
hw/rtl/deadlock_detector_unit.sv
hw/rtl/dd_checker.sv
test/deadlock_detector_unit_test.sv
